/* hdl/newton_polynomial_root_in_interval_core_defines.svh */
// ----------------------------------------------------------------------------
// newton_polynomial_root_in_interval_core_defines
// Assertion macros shared by the Newton root core.
// ----------------------------------------------------------------------------
`ifndef NEWTON_POLYNOMIAL_ROOT_IN_INTERVAL_CORE_DEFINES_SVH
`define NEWTON_POLYNOMIAL_ROOT_IN_INTERVAL_CORE_DEFINES_SVH
// assert that a property holds at every clock edge outside reset
`define NPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// trigger implies the consequent in the next cycle
`define NPR_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/npr_pkg.sv */
// ----------------------------------------------------------------------------
// npr_pkg
// Types and constants shared by the Newton root core.
// ----------------------------------------------------------------------------
`default_nettype none
package npr_pkg;
  localparam int VW = 48;
  localparam int TW = 33;
  localparam int IW = 7;
  localparam int NCOEF = 7;
  localparam int AW = 3;

  localparam logic [AW:0] REG_TOL = 4'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POLY_INIT,
    ST_POLY_MUL,
    ST_POLY_ADD,
    ST_RESID,
    ST_DIFF,
    ST_DIV,
    ST_DERIV,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PT_X,
    PT_XP,
    PT_XM
  } pt_t;
endpackage
`default_nettype wire

/* hdl/newton_polynomial_root_in_interval_core.sv */
// ----------------------------------------------------------------------------
// newton_polynomial_root_in_interval_core
// Newton search for P(x) = target on [lower, upper], signed fixed point.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; busy then stays high
// until the result word is shown on the out_ ports for one cycle with
// out_valid. The receiver cannot stall. Each Newton step evaluates P three
// times on one shared multiply unit: one setup step plus DEGREE
// multiply/add rounds (four 24x24 partial products, one scale and
// saturate, one add). It then runs one restoring divider twice (one
// quotient bit per cycle plus a final decision step) and also passes
// through the residual, tolerance test, derivative load and update states.
// An item runs at most MAX_STEPS Newton steps from accept to result.
`default_nettype none
`include "newton_polynomial_root_in_interval_core_defines.svh"
module newton_polynomial_root_in_interval_core #(
  parameter int DEGREE    = 6,
  parameter int MAX_STEPS = 100,
  parameter int FRAC_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [47:0]       in_target,
  input  wire logic signed [47:0]       in_lower,
  input  wire logic signed [47:0]       in_upper,
  output logic                          out_valid,
  output logic                          out_found,
  output logic signed [47:0]            out_root,
  output logic [6:0]                    out_iterations,
  input  wire logic                     cfg_we,
  input  wire logic [3:0]               cfg_index,
  input  wire logic [47:0]              cfg_data
);
  import npr_pkg::*;

  // constants worked out at elaboration
  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint HRAW = (ONE + 500000) / 1000000;
  localparam longint HV   = (HRAW < 1) ? 1 : HRAW;
  localparam longint THR  = (ONE + 64'd500000000000) / 64'd1000000000000;
  localparam int     NW   = VW + FRAC_BITS;          // dividend width
  localparam int     DBW  = $clog2(NW + 1);
  localparam int     SW   = $clog2(MAX_STEPS + 1);
  localparam int     HW   = VW / 2;                  // partial product half
  localparam logic [2:0] MC_LAST = 3'd4;             // scale cycle of a multiply
  localparam logic signed [VW-1:0] H2 = VW'(2 * HV);
  localparam logic signed [VW-1:0] HS = VW'(HV);
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // configuration
  logic signed [VW-1:0] coef_r [NCOEF];
  logic [TW-1:0]        tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= '0;
      tol_r <= TW'(43);
    end else if (cfg_we) begin
      if (cfg_index < 4'(NCOEF)) coef_r[cfg_index[AW-1:0]] <= cfg_data;
      else if (cfg_index == REG_TOL) tol_r <= cfg_data[TW-1:0];
    end
  end

  function automatic logic signed [VW-1:0] sat_w(input logic signed [VW+1:0] v);
    if (v > (VW+2)'(VMAX)) return VMAX;
    if (v < (VW+2)'(VMIN)) return VMIN;
    return v[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag_f(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : v;
  endfunction

  // magnitude to saturated signed
  function automatic logic signed [VW-1:0] sat_m(input logic neg,
      input logic [2*VW-1:0] m);
    if (neg) begin
      if (m > (2*VW)'({1'b1, {(VW-1){1'b0}}})) return VMIN;
      return VW'(-m[VW-1:0]);
    end
    if (m > (2*VW)'(VMAX)) return VMAX;
    return m[VW-1:0];
  endfunction

  // sequencer registers
  state_t               st_r, st_nxt;
  pt_t                  pt_r, pt_nxt;
  logic signed [VW-1:0] tgt_r, lo_r, hi_r, x_r, xe_r, acc_r, f_r, pp_r, d_r;
  logic signed [VW-1:0] tgt_nxt, lo_nxt, hi_nxt, x_nxt, xe_nxt, acc_nxt, f_nxt;
  logic signed [VW-1:0] pp_nxt, d_nxt;
  logic [AW-1:0]        ci_r, ci_nxt;
  logic [SW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        it_r, it_nxt;
  logic                 fnd_r, fnd_nxt, div2_r, div2_nxt;
  logic                 ov_r, ov_nxt, ovo_nxt;
  logic signed [VW-1:0] pr_r, pr_nxt;  // product register

  // multiplier state: four half-width partial products summed, then scaled
  logic [2*VW-1:0] prod_r, prod_nxt;
  logic [2:0]      mc_r, mc_nxt;

  // divider state (restoring, one quotient bit a cycle)
  logic [NW-1:0]   dq_r, dq_nxt;     // dividend shifting out, quotient in
  logic [VW:0]     rem_r, rem_nxt;
  logic [VW-1:0]   dv_r, dv_nxt;
  logic [DBW-1:0]  dc_r, dc_nxt;
  logic            dneg_r, dneg_nxt;

  // shared multiplier: one 24x24 piece of |acc| * |x| per cycle
  logic [VW-1:0]   mul_ma, mul_mb;
  logic [HW-1:0]   mul_a, mul_b;
  logic [VW-1:0]   mul_p;
  logic [2*VW-1:0] mul_pe, mul_sh;
  logic [VW:0]     rsub;
  logic signed [VW-1:0] qv;
  assign mul_ma = mag_f(acc_r);
  assign mul_mb = mag_f(xe_r);
  assign mul_a  = mc_r[1] ? mul_ma[VW-1:HW] : mul_ma[HW-1:0];
  assign mul_b  = mc_r[0] ? mul_mb[VW-1:HW] : mul_mb[HW-1:0];
  assign mul_p  = VW'(mul_a) * VW'(mul_b);
  assign mul_pe = (2*VW)'(mul_p);
  // weight of the piece: low*low, cross terms, high*high
  assign mul_sh = (mc_r[1] & mc_r[0]) ? (mul_pe << (2*HW)) :
                  (mc_r[1] ^ mc_r[0]) ? (mul_pe << HW) : mul_pe;
  assign rsub = {rem_r[VW-1:0], dq_r[NW-1]} - {1'b0, dv_r};
  // quotient over VW bits: dq bits above VW-1 mean saturation
  assign qv = sat_m(dneg_r, {{VW{1'b0}}, dq_r[VW-1:0]} |
                    ((dq_r[NW-1:VW] != '0 || ov_r) ? {(2*VW){1'b1}} : '0));

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt; tgt_r <= tgt_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    x_r <= x_nxt; xe_r <= xe_nxt; acc_r <= acc_nxt; f_r <= f_nxt;
    pp_r <= pp_nxt; d_r <= d_nxt; ci_r <= ci_nxt; k_r <= k_nxt;
    it_r <= it_nxt; fnd_r <= fnd_nxt; div2_r <= div2_nxt; pr_r <= pr_nxt;
    dq_r <= dq_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt; dc_r <= dc_nxt;
    dneg_r <= dneg_nxt; ov_r <= ov_nxt; prod_r <= prod_nxt; mc_r <= mc_nxt;
  end

  logic signed [VW:0] sum_lu;
  logic [2*VW-1:0]    ps;
  assign sum_lu = {lo_r[VW-1], lo_r} + {hi_r[VW-1], hi_r};
  assign ps     = prod_r >> FRAC_BITS;

  // load divider with a * 2^FRAC_BITS / b
  task automatic div_load(input logic signed [VW-1:0] a,
                          input logic signed [VW-1:0] b);
    dq_nxt   = {mag_f(a), {FRAC_BITS{1'b0}}};
    rem_nxt  = '0;
    dv_nxt   = mag_f(b);
    dc_nxt   = DBW'(NW);
    dneg_nxt = a[VW-1] ^ b[VW-1];
    ov_nxt   = 1'b0;
  endtask

  always_comb begin
    st_nxt = st_r; pt_nxt = pt_r; tgt_nxt = tgt_r; lo_nxt = lo_r; hi_nxt = hi_r;
    x_nxt = x_r; xe_nxt = xe_r; acc_nxt = acc_r; f_nxt = f_r; pp_nxt = pp_r;
    d_nxt = d_r; ci_nxt = ci_r; k_nxt = k_r; it_nxt = it_r; fnd_nxt = fnd_r;
    div2_nxt = div2_r; pr_nxt = pr_r; dq_nxt = dq_r; rem_nxt = rem_r;
    dv_nxt = dv_r; dc_nxt = dc_r; dneg_nxt = dneg_r; ov_nxt = ov_r;
    prod_nxt = prod_r; mc_nxt = mc_r;
    ovo_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          tgt_nxt = in_target; lo_nxt = in_lower; hi_nxt = in_upper;
          k_nxt = '0; it_nxt = '0; fnd_nxt = 1'b0;
          st_nxt = ST_RESID;  // first: midpoint
          pt_nxt = PT_X;
          div2_nxt = 1'b1;    // flag: midpoint pending
        end
      end
      ST_RESID: begin
        if (div2_r) begin
          x_nxt = sum_lu[VW:1];  // floor halving
          div2_nxt = 1'b0;
          st_nxt = ST_POLY_INIT;
        end else begin
          // residual just evaluated at x
          f_nxt = sat_w((VW+2)'(acc_r) - (VW+2)'(tgt_r));
          st_nxt = ST_DIFF;
        end
      end
      ST_POLY_INIT: begin
        unique case (pt_r)
          PT_X:    xe_nxt = x_r;
          PT_XP:   xe_nxt = sat_w((VW+2)'(x_r) + (VW+2)'(HS));
          default: xe_nxt = sat_w((VW+2)'(x_r) - (VW+2)'(HS));
        endcase
        acc_nxt  = coef_r[AW'(DEGREE)];
        ci_nxt   = AW'(DEGREE);
        prod_nxt = '0;
        mc_nxt   = '0;
        st_nxt   = ST_POLY_MUL;
      end
      ST_POLY_MUL: begin
        if (mc_r != MC_LAST) begin
          prod_nxt = prod_r + mul_sh;
          mc_nxt   = mc_r + 1'b1;
        end else begin
          pr_nxt   = sat_m(acc_r[VW-1] ^ xe_r[VW-1], ps);
          ci_nxt   = ci_r - 1'b1;
          prod_nxt = '0;
          mc_nxt   = '0;
          st_nxt   = ST_POLY_ADD;
        end
      end
      ST_POLY_ADD: begin
        acc_nxt = sat_w((VW+2)'(pr_r) + (VW+2)'(coef_r[ci_r]));
        if (ci_r == '0) begin
          unique case (pt_r)
            PT_X:  st_nxt = ST_RESID;
            PT_XP: begin
              pp_nxt = sat_w((VW+2)'(pr_r) + (VW+2)'(coef_r[ci_r]));
              pt_nxt = PT_XM; st_nxt = ST_POLY_INIT;
            end
            default: st_nxt = ST_DERIV;
          endcase
        end else begin
          st_nxt = ST_POLY_MUL;
        end
      end
      ST_DIFF: begin
        if ({1'b0, mag_f(f_r)} < (VW+1)'(tol_r)) begin
          fnd_nxt = 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          pt_nxt = PT_XP;
          st_nxt = ST_POLY_INIT;
        end
      end
      ST_DERIV: begin
        div_load(sat_w((VW+2)'(pp_r) - (VW+2)'(acc_r)), H2);
        div2_nxt = 1'b0;
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dc_r != '0) begin
          if (!rsub[VW]) rem_nxt = rsub;
          else rem_nxt = {rem_r[VW-1:0], dq_r[NW-1]};
          dq_nxt = {dq_r[NW-2:0], !rsub[VW]};
          dc_nxt = dc_r - 1'b1;
        end else if (!div2_r) begin
          // derivative quotient ready
          d_nxt = qv;
          if (qv == '0 || {1'b0, mag_f(qv)} < (VW+1)'(THR)) begin
            st_nxt = ST_DONE;
          end else begin
            div_load(f_r, qv);
            div2_nxt = 1'b1;
          end
        end else begin
          st_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        x_nxt  = sat_w((VW+2)'(x_r) - (VW+2)'(qv));
        it_nxt = it_r + 1'b1;
        k_nxt  = k_r + 1'b1;
        div2_nxt = 1'b0;
        if (sat_w((VW+2)'(x_r) - (VW+2)'(qv)) < lo_r ||
            sat_w((VW+2)'(x_r) - (VW+2)'(qv)) > hi_r ||
            k_r + 1'b1 == SW'(MAX_STEPS)) begin
          st_nxt = ST_DONE;
        end else begin
          pt_nxt = PT_X;
          st_nxt = ST_POLY_INIT;
        end
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if (ovo_nxt) ov_nxt = 1'b1;
  end

  assign busy           = (st_r != ST_IDLE);
  assign out_valid      = (st_r == ST_DONE);
  assign out_found      = fnd_r;
  assign out_root       = fnd_r ? x_r : '0;
  assign out_iterations = it_r;

  `NPR_ASSERT_NEXT(a_done_one, clk, rst_n, out_valid, !out_valid, "double result")
  `NPR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start ignored")
  `NPR_ASSERT(a_root_zero, clk, rst_n, !out_valid || out_found || out_root == '0, "bad root")
  `NPR_ASSERT(a_valid_busy, clk, rst_n, !out_valid || busy, "result while idle")
endmodule
`default_nettype wire
